### sv/stok_pkg.sv
// shared types and constants for the s-expression tokenizer
// no dependencies; every other file in this folder imports it
package stok_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int SLOT_COUNT          = 3;
   localparam int OUT_OFFSET_BITS     = 16;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0d;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7a;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;

   typedef enum logic [3:0] {
      KIND_OPEN   = 4'd0,
      KIND_CLOSE  = 4'd1,
      KIND_QUOTE  = 4'd2,
      KIND_STRING = 4'd3,
      KIND_BOOL   = 4'd4,
      KIND_CHAR   = 4'd5,
      KIND_HASH   = 4'd6,
      KIND_SYMBOL = 4'd7,
      KIND_END    = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNREC   = 2'd1,
      STATUS_UNTERM  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_STRING  = 3'd1,
      MODE_HASH    = 3'd2,
      MODE_HASHBSL = 3'd3,
      MODE_SYMBOL  = 3'd4,
      MODE_STOPPED = 3'd5
   } mode_type;

   typedef struct packed {
      kind_type                   kind;
      logic [7:0]                 value;
      logic [OUT_OFFSET_BITS-1:0] start_offset;
      logic [OUT_OFFSET_BITS-1:0] end_offset;
      status_type                 status;
   } res_type;

   // all results caused by one byte, packed from slot 0 up
   typedef struct packed {
      res_type [SLOT_COUNT-1:0] slot;
      logic [1:0]               count;
   } bundle_type;

endpackage

### sv/stok_front.sv
// front end: scan-mode state machine, classifies each byte into a bundle of results
// depends on stok_pkg
module stok_front
   import stok_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   output logic       bundle_valid,
   output bundle_type bundle
);

   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] begin_ff, begin_in;
   status_type             cause_ff, cause_in;

   res_type    s0, s1, s2;
   logic       v0, v1, v2;
   logic       do_idle;
   logic [1:0] n;

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic res_type mk(input kind_type k, input logic [7:0] val,
                                  input logic [OFFSET_BITS-1:0] s,
                                  input logic [OFFSET_BITS-1:0] e,
                                  input status_type st);
      res_type r;
      r.kind         = k;
      r.value        = val;
      r.start_offset = OUT_OFFSET_BITS'(s);
      r.end_offset   = OUT_OFFSET_BITS'(e);
      r.status       = st;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         cause_ff <= STATUS_OK;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         cause_ff <= cause_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      cause_in = cause_ff;
      v0 = 1'b0;
      v1 = 1'b0;
      v2 = 1'b0;
      s0 = '0;
      s1 = '0;
      s2 = '0;
      do_idle = 1'b0;
      if (accept) begin
         if (text_byte == CHAR_NUL) begin
            // end of text: flush the pending token, then the end marker
            unique case (mode_ff)
               MODE_SYMBOL: begin
                  v0 = 1'b1;
                  s0 = mk(KIND_SYMBOL, 8'd0, begin_ff, pos_ff, STATUS_OK);
               end
               MODE_HASH: begin
                  v0 = 1'b1;
                  s0 = mk(KIND_HASH, 8'd0, begin_ff, sat_inc(begin_ff), STATUS_OK);
               end
               MODE_HASHBSL: begin
                  v0 = 1'b1;
                  s0 = mk(KIND_HASH, 8'd0, begin_ff, sat_inc(begin_ff), STATUS_OK);
                  v1 = 1'b1;
                  s1 = mk(KIND_SYMBOL, 8'd0, sat_inc(begin_ff), pos_ff, STATUS_OK);
               end
               default: begin
               end
            endcase
            v2 = 1'b1;
            s2 = mk(KIND_END, 8'd0, pos_ff, pos_ff,
                    (mode_ff == MODE_STRING) ? STATUS_UNTERM : cause_ff);
            mode_in  = MODE_IDLE;
            pos_in   = '0;
            begin_in = '0;
            cause_in = STATUS_OK;
         end else begin
            pos_in = sat_inc(pos_ff);
            unique case (mode_ff)
               MODE_IDLE: begin
                  do_idle = 1'b1;
               end
               MODE_STRING: begin
                  if (text_byte == CHAR_DQUOTE) begin
                     v2 = 1'b1;
                     s2 = mk(KIND_STRING, 8'd0, begin_ff, sat_inc(pos_ff), STATUS_OK);
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_HASH: begin
                  if (text_byte == CHAR_LOWER_T || text_byte == CHAR_LOWER_F) begin
                     v2 = 1'b1;
                     s2 = mk(KIND_BOOL, {7'd0, text_byte == CHAR_LOWER_T}, begin_ff,
                             sat_inc(pos_ff), STATUS_OK);
                     mode_in = MODE_IDLE;
                  end else if (text_byte == CHAR_BACKSLASH) begin
                     mode_in = MODE_HASHBSL;
                  end else begin
                     // bare hash, then the byte starts over
                     v0 = 1'b1;
                     s0 = mk(KIND_HASH, 8'd0, begin_ff, sat_inc(begin_ff), STATUS_OK);
                     mode_in = MODE_IDLE;
                     do_idle = 1'b1;
                  end
               end
               MODE_HASHBSL: begin
                  v2 = 1'b1;
                  s2 = mk(KIND_CHAR, text_byte, begin_ff, sat_inc(pos_ff), STATUS_OK);
                  mode_in = MODE_IDLE;
               end
               MODE_SYMBOL: begin
                  if (!(text_byte >= CHAR_UPPER_A && text_byte <= CHAR_LOWER_Z)) begin
                     v0 = 1'b1;
                     s0 = mk(KIND_SYMBOL, 8'd0, begin_ff, pos_ff, STATUS_OK);
                     mode_in = MODE_IDLE;
                     do_idle = 1'b1;
                  end
               end
               MODE_STOPPED: begin
               end
               default: begin
               end
            endcase
            if (do_idle) begin
               if (text_byte inside {CHAR_SPACE, CHAR_LF, CHAR_TAB, CHAR_CR}) begin
                  mode_in = MODE_IDLE;
               end else if (text_byte == CHAR_LPAREN) begin
                  v2 = 1'b1;
                  s2 = mk(KIND_OPEN, 8'd0, pos_ff, sat_inc(pos_ff), STATUS_OK);
               end else if (text_byte == CHAR_RPAREN) begin
                  v2 = 1'b1;
                  s2 = mk(KIND_CLOSE, 8'd0, pos_ff, sat_inc(pos_ff), STATUS_OK);
               end else if (text_byte == CHAR_QUOTE) begin
                  v2 = 1'b1;
                  s2 = mk(KIND_QUOTE, 8'd0, pos_ff, sat_inc(pos_ff), STATUS_OK);
               end else if (text_byte == CHAR_DQUOTE) begin
                  mode_in  = MODE_STRING;
                  begin_in = pos_ff;
               end else if (text_byte == CHAR_HASH) begin
                  mode_in  = MODE_HASH;
                  begin_in = pos_ff;
               end else if (text_byte >= CHAR_UPPER_A && text_byte <= CHAR_LOWER_Z) begin
                  mode_in  = MODE_SYMBOL;
                  begin_in = pos_ff;
               end else begin
                  mode_in  = MODE_STOPPED;
                  cause_in = STATUS_UNREC;
               end
            end
         end
      end
   end

   // pack the valid results from slot 0 up
   always_comb begin
      bundle = '0;
      n = 2'd0;
      if (v0) begin
         bundle.slot[n] = s0;
         n = n + 2'd1;
      end
      if (v1) begin
         bundle.slot[n] = s1;
         n = n + 2'd1;
      end
      if (v2) begin
         bundle.slot[n] = s2;
         n = n + 2'd1;
      end
      bundle.count = n;
      bundle_valid = accept && (v0 || v1 || v2);
   end

endmodule

### sv/stok_queue.sv
// short queue of result bundles between the front end and the back end
// depends on stok_pkg
module stok_queue
   import stok_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type wr_data,
   output logic       full,
   input  logic       pop,
   output bundle_type rd_data,
   output logic       empty
);

   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(DEPTH);

   bundle_type            mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign full    = (count_ff == COUNT_FULL);
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/stok_back.sv
// back end: walks the slots of the head bundle, one result per transfer, into the output register
// depends on stok_pkg
module stok_back
   import stok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_pop,
   output res_type    out_res,
   output logic       out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   res_type    res_ff, res_in;
   logic       last_ff, last_in;
   logic       take;
   logic       is_last;

   // output register frees up when empty or being taken this cycle
   assign take    = (!valid_ff || out_pop) && !q_empty;
   assign is_last = (idx_ff == head.count - 2'd1);
   assign q_pop   = take && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      res_in   = res_ff;
      last_in  = last_ff;
      if (take) begin
         valid_in = 1'b1;
         res_in   = head.slot[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_last  = last_ff;

endmodule

### sv/s_expression_tokenizer_core.sv
// s-expression tokenizer, top level: front end, bundle queue and back end
// depends on stok_pkg, stok_front, stok_queue, stok_back
//
// Input side is a queue write port: drive req_text_byte and raise req_push;
// the byte transfers on a clock edge where req_full is low. Byte 0 ends the text.
// Result side is a queue read port: while rsp_empty is low the oldest token
// is on the rsp_ ports and transfers on an edge where rsp_pop is high.
// One byte can be taken every cycle while req_full is low. A byte makes zero
// to three results; the back end hands out one result per cycle while rsp_pop
// is high, so the output port sets the sustained rate when bytes keep making
// more than one result. The first result of a byte passes through the bundle
// queue and then the output register, provided the queue ahead of it is drained.
// When the receiver stalls, results pile up in the bundle queue (QUEUE_DEPTH
// bundles) plus the output register; req_full rises once the queue is full.
// rsp_last marks the final result caused by one byte.
// Synchronous reset puts the scanner in idle at offset 0 and empties the queue.
module s_expression_tokenizer_core
   import stok_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_value,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_end_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   logic       accept;
   logic       bundle_valid;
   bundle_type bundle;
   bundle_type head;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   logic       out_valid;
   res_type    out_res;
   logic       out_last;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   stok_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .bundle_valid(bundle_valid),
      .bundle      (bundle)
   );

   stok_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (bundle_valid),
      .wr_data(bundle),
      .full   (q_full),
      .pop    (q_pop),
      .rd_data(head),
      .empty  (q_empty)
   );

   stok_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .out_valid(out_valid),
      .out_pop  (rsp_pop),
      .out_res  (out_res),
      .out_last (out_last)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_kind         = out_res.kind;
   assign rsp_value        = out_res.value;
   assign rsp_start_offset = out_res.start_offset;
   assign rsp_end_offset   = out_res.end_offset;
   assign rsp_status       = out_res.status;
   assign rsp_last         = out_last;

endmodule

### verif/testbench.sv
// testbench for s_expression_tokenizer_core: drives text bytes, predicts the tokens
// and compares every result transfer; depends on stok_pkg and the tokenizer RTL
`timescale 1ns / 1ps

import stok_pkg::*;

class token_scoreboard;
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
      logic [15:0] first;
      logic [15:0] past;
      status_type  status;
      logic        last;
   } token_type;

   token_type   awaited[$];
   mode_type    mode;
   logic [15:0] cursor;
   logic [15:0] token_start;
   status_type  cause;
   int          errors;

   function new();
      restart();
      errors = 0;
   endfunction

   function void restart();
      mode        = MODE_IDLE;
      cursor      = 16'd0;
      token_start = 16'd0;
      cause       = STATUS_OK;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   // offsets stick at the top value
   function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   function void add(kind_type k, logic [7:0] v, logic [15:0] s, logic [15:0] e,
                     status_type st);
      token_type t;
      t.kind   = k;
      t.value  = v;
      t.first  = s;
      t.past   = e;
      t.status = st;
      t.last   = 1'b0;
      awaited.push_back(t);
   endfunction

   // byte seen with no token open
   function void fresh_byte(logic [7:0] b, logic [15:0] p);
      case (b)
         CHAR_SPACE, CHAR_LF, CHAR_TAB, CHAR_CR: ;
         CHAR_LPAREN: add(KIND_OPEN, 8'h00, p, bump(p), STATUS_OK);
         CHAR_RPAREN: add(KIND_CLOSE, 8'h00, p, bump(p), STATUS_OK);
         CHAR_QUOTE:  add(KIND_QUOTE, 8'h00, p, bump(p), STATUS_OK);
         CHAR_DQUOTE: begin
            mode        = MODE_STRING;
            token_start = p;
         end
         CHAR_HASH: begin
            mode        = MODE_HASH;
            token_start = p;
         end
         default: begin
            if (b >= CHAR_UPPER_A && b <= CHAR_LOWER_Z) begin
               mode        = MODE_SYMBOL;
               token_start = p;
            end else begin
               mode  = MODE_STOPPED;
               cause = STATUS_UNREC;
            end
         end
      endcase
   endfunction

   function void note_byte(logic [7:0] b);
      int          base;
      logic [15:0] p;
      status_type  st;
      token_type   t;
      base = awaited.size();
      p    = cursor;
      if (b == CHAR_NUL) begin
         st = cause;
         case (mode)
            MODE_SYMBOL: add(KIND_SYMBOL, 8'h00, token_start, p, STATUS_OK);
            MODE_HASH:   add(KIND_HASH, 8'h00, token_start, bump(token_start), STATUS_OK);
            MODE_HASHBSL: begin
               add(KIND_HASH, 8'h00, token_start, bump(token_start), STATUS_OK);
               add(KIND_SYMBOL, 8'h00, bump(token_start), p, STATUS_OK);
            end
            MODE_STRING: st = STATUS_UNTERM;
            default: ;
         endcase
         add(KIND_END, 8'h00, p, p, st);
         restart();
      end else begin
         case (mode)
            MODE_IDLE: fresh_byte(b, p);
            MODE_STRING: begin
               if (b == CHAR_DQUOTE) begin
                  add(KIND_STRING, 8'h00, token_start, bump(p), STATUS_OK);
                  mode = MODE_IDLE;
               end
            end
            MODE_HASH: begin
               if (b == CHAR_LOWER_T || b == CHAR_LOWER_F) begin
                  add(KIND_BOOL, (b == CHAR_LOWER_T) ? 8'h01 : 8'h00, token_start, bump(p),
                      STATUS_OK);
                  mode = MODE_IDLE;
               end else if (b == CHAR_BACKSLASH) begin
                  mode = MODE_HASHBSL;
               end else begin
                  add(KIND_HASH, 8'h00, token_start, bump(token_start), STATUS_OK);
                  mode = MODE_IDLE;
                  fresh_byte(b, p);
               end
            end
            MODE_HASHBSL: begin
               add(KIND_CHAR, b, token_start, bump(p), STATUS_OK);
               mode = MODE_IDLE;
            end
            MODE_SYMBOL: begin
               if (!(b >= CHAR_UPPER_A && b <= CHAR_LOWER_Z)) begin
                  add(KIND_SYMBOL, 8'h00, token_start, p, STATUS_OK);
                  mode = MODE_IDLE;
                  fresh_byte(b, p);
               end
            end
            default: ; // stopped: byte ignored but still counted
         endcase
         cursor = bump(p);
      end
      if (awaited.size() > base) begin
         t      = awaited.pop_back();
         t.last = 1'b1;
         awaited.push_back(t);
      end
   endfunction

   function void report(string msg);
      if (errors < 10)
         $display("%0t: %s", $time, msg);
      errors++;
   endfunction

   function void check_token(logic [3:0] k, logic [7:0] v, logic [15:0] s, logic [15:0] e,
                             logic [1:0] st, logic l);
      token_type t;
      if (awaited.size() == 0) begin
         report($sformatf("unexpected token: kind %0d start %0d end %0d", k, s, e));
         return;
      end
      t = awaited.pop_front();
      if (t.kind !== k || t.value !== v || t.first !== s || t.past !== e ||
          t.status !== st || t.last !== l)
         report($sformatf({"token mismatch: expected kind %0d value %0h [%0d,%0d) ",
                           "status %0d last %0b, got kind %0d value %0h [%0d,%0d) ",
                           "status %0d last %0b"},
                          t.kind, t.value, t.first, t.past, t.status, t.last,
                          k, v, s, e, st, l));
   endfunction
endclass

module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_text_byte = 8'h00;
   logic        rsp_pop = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [3:0]  rsp_kind;
   logic [7:0]  rsp_value;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_end_offset;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   int              idle_pct = 34;
   int              item_count = 0;
   logic [7:0]      text_buf[$];
   token_scoreboard predicted = new();

   s_expression_tokenizer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_value        (rsp_value),
      .rsp_start_offset (rsp_start_offset),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         predicted.check_token(rsp_kind, rsp_value, rsp_start_offset, rsp_end_offset,
                               rsp_status, rsp_last);
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_text_byte <= b;
      do
         @(posedge clock);
      while (req_full);
      predicted.note_byte(b);
      item_count++;
      @(negedge clock);
   endtask

   task automatic push_text();
      foreach (text_buf[i])
         push_byte(text_buf[i]);
      text_buf = {};
   endtask

   function automatic logic [7:0] letter();
      return 8'($urandom_range(CHAR_LOWER_Z, CHAR_UPPER_A));
   endfunction

   function automatic logic [7:0] blank();
      case ($urandom_range(3))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   function automatic void add_token();
      int         n;
      logic [7:0] b;
      case ($urandom_range(19))
         0, 1, 2: begin
            case ($urandom_range(2))
               0:       text_buf.push_back(CHAR_LPAREN);
               1:       text_buf.push_back(CHAR_RPAREN);
               default: text_buf.push_back(CHAR_QUOTE);
            endcase
         end
         3, 4, 5: begin
            text_buf.push_back(CHAR_DQUOTE);
            n = $urandom_range(5);
            repeat (n) begin
               b = 8'($urandom_range(255, 1));
               if (b == CHAR_DQUOTE)
                  b = CHAR_HASH;
               text_buf.push_back(b);
            end
            text_buf.push_back(CHAR_DQUOTE);
         end
         6, 7: begin
            text_buf.push_back(CHAR_HASH);
            text_buf.push_back($urandom_range(1) ? CHAR_LOWER_T : CHAR_LOWER_F);
         end
         8, 9: begin
            text_buf.push_back(CHAR_HASH);
            text_buf.push_back(CHAR_BACKSLASH);
            text_buf.push_back(8'($urandom_range(255, 1)));
         end
         10: begin
            text_buf.push_back(CHAR_HASH);
            text_buf.push_back(blank());
         end
         11, 12, 13, 14: begin
            n = $urandom_range(6, 1);
            repeat (n) text_buf.push_back(letter());
            text_buf.push_back(blank());
         end
         15, 16, 17: text_buf.push_back(blank());
         default: text_buf.push_back(8'($urandom_range(255, 1)));
      endcase
   endfunction

   // a text of random tokens, sometimes cut off inside a token
   function automatic void random_text();
      int n;
      n = $urandom_range(15, 1);
      repeat (n) add_token();
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: begin
               text_buf.push_back(CHAR_DQUOTE);
               text_buf.push_back(letter());
            end
            1: text_buf.push_back(CHAR_HASH);
            2: begin
               text_buf.push_back(CHAR_HASH);
               text_buf.push_back(CHAR_BACKSLASH);
            end
            default: text_buf.push_back(letter());
         endcase
      end
      text_buf.push_back(CHAR_NUL);
   endfunction

   initial begin
      logic [7:0] opening[$];
      opening = '{CHAR_LPAREN, CHAR_QUOTE, CHAR_DQUOTE, CHAR_DQUOTE,
                  CHAR_HASH, CHAR_LOWER_T, CHAR_HASH, CHAR_LOWER_F,
                  CHAR_HASH, CHAR_BACKSLASH, 8'hff, CHAR_HASH, CHAR_LPAREN,
                  CHAR_UPPER_A, CHAR_LOWER_Z, CHAR_RPAREN, CHAR_TAB, CHAR_LF, CHAR_NUL,
                  CHAR_HASH, CHAR_BACKSLASH, CHAR_NUL,
                  CHAR_DQUOTE, CHAR_NUL,
                  8'h01, CHAR_UPPER_A, CHAR_NUL};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      text_buf = opening;
      push_text();

      while (item_count < 430) begin
         // no idling on either side for a stretch in the middle
         idle_pct = (item_count >= 150 && item_count < 280) ? 0 : 34;
         random_text();
         push_text();
      end
      idle_pct = 34;
      req_push <= 1'b0;

      while (predicted.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (predicted.errors == 0 && predicted.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

### files.f
sv/stok_pkg.sv
sv/stok_front.sv
sv/stok_queue.sv
sv/stok_back.sv
sv/s_expression_tokenizer_core.sv
verif/testbench.sv
